FILE: rtl/rvdq_pkg.sv
`default_nettype none
package rvdq_pkg;

  localparam int DATA_W  = 32;
  localparam int CMD_W   = 3;
  localparam int COUNT_W = 5;
  localparam int STAT_W  = 2;

  // command codes, codes above CMD_PEEK act as a peek
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REVERSE    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_PEEK       = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_POP_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_PUSH_FULL = 2'd2;

  localparam logic [DATA_W-1:0] EMPTY_WORD = {DATA_W{1'b1}};

  typedef logic [DATA_W-1:0] word_t;

endpackage
`default_nettype wire

FILE: rtl/rvdq_store.sv
`default_nettype none
module rvdq_store import rvdq_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [IDX_W-1:0] waddr,
  input  wire word_t            wdata,
  input  wire logic [IDX_W-1:0] raddr_a,
  input  wire logic [IDX_W-1:0] raddr_b,
  output word_t                 rdata_a,
  output word_t                 rdata_b
);

  word_t mem [DEPTH];

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

FILE: rtl/reversible_deque_top.sv
`default_nettype none
// channel   direction  handshake            payload
// command   in         start, busy          cmd[2:0], value[31:0] signed
// result    out        done (1-cycle beat)  front_value, back_value, count, status
//
// a command runs through the exec state (update pointers and write the store), the
// read state (read both ends from the store) and the resp state (result on the ports);
// a new command can be taken in the resp state, but not while exec or read is busy
// rst is synchronous and clears pointers, count and reversal; the store is not cleared
// the receiver cannot stall: each result beat shows for exactly one cycle
module reversible_deque_top import rvdq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [CMD_W-1:0]         cmd,
  input  wire logic signed [DATA_W-1:0] value,
  output logic                          busy,
  output logic                          done,
  output logic signed [DATA_W-1:0]      front_value,
  output logic signed [DATA_W-1:0]      back_value,
  output logic [COUNT_W-1:0]            count,
  output logic [STAT_W-1:0]             status
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int SUM_W = ((IDX_W > OCC_W) ? IDX_W : OCC_W) + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0]        state, state_next;
  logic [IDX_W-1:0]  first, first_next;
  logic [OCC_W-1:0]  occ, occ_next;
  logic              rev, rev_next;
  logic [CMD_W-1:0]  cmd_q;
  word_t             value_q;
  logic [STAT_W-1:0] stat_q, stat_next;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [IDX_W-1:0]  raddr_a, raddr_b;
  word_t             rdata_a, rdata_b;
  word_t             head_v, tail_v;
  logic              accept, full, empty;

  function automatic logic [IDX_W-1:0] slot_at(logic [IDX_W-1:0] base,
                                               logic [OCC_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(off);
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] slot_prev(logic [IDX_W-1:0] s);
    return (s == '0) ? IDX_W'(DEPTH - 1) : s - IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] slot_next(logic [IDX_W-1:0] s);
    return (s == IDX_W'(DEPTH - 1)) ? '0 : s + IDX_W'(1);
  endfunction

  assign busy   = (state == S_EXEC) || (state == S_READ);
  assign accept = start && !busy;
  assign full   = (occ == OCC_W'(DEPTH));
  assign empty  = (occ == '0);

  // pointer update and store write, used in the exec cycle
  always_comb begin
    first_next = first;
    occ_next   = occ;
    rev_next   = rev;
    stat_next  = STAT_OK;
    we         = 1'b0;
    waddr      = slot_at(first, occ);
    unique case (cmd_q)
      CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        if (full) begin
          stat_next = STAT_PUSH_FULL;
        end else begin
          we       = 1'b1;
          occ_next = occ + OCC_W'(1);
          // push front on a plain queue or push back on a reversed one
          if ((cmd_q == CMD_PUSH_FRONT) != rev) begin
            first_next = slot_prev(first);
            waddr      = slot_prev(first);
          end
        end
      end
      CMD_POP_BACK, CMD_POP_FRONT: begin
        if (empty) begin
          stat_next = STAT_POP_EMPTY;
        end else begin
          occ_next = occ - OCC_W'(1);
          if (occ == OCC_W'(1)) begin
            first_next = '0;
          end else if ((cmd_q == CMD_POP_FRONT) != rev) begin
            first_next = slot_next(first);
          end
        end
      end
      CMD_REVERSE: begin
        rev_next = !rev;
      end
      default: begin
      end
    endcase
  end

  assign raddr_a = first;
  assign raddr_b = slot_at(first, empty ? '0 : occ - OCC_W'(1));

  rvdq_store #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .we      (we && (state == S_EXEC)),
    .waddr   (waddr),
    .wdata   (value_q),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_comb begin
    unique case (state)
      S_IDLE:  state_next = accept ? S_EXEC : S_IDLE;
      S_EXEC:  state_next = S_READ;
      S_READ:  state_next = S_RESP;
      S_RESP:  state_next = accept ? S_EXEC : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      first <= '0;
      occ   <= '0;
      rev   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_EXEC) begin
        first <= first_next;
        occ   <= occ_next;
        rev   <= rev_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= cmd;
      value_q <= value;
    end
    if (state == S_EXEC) begin
      stat_q <= stat_next;
    end
  end

  assign head_v      = empty ? EMPTY_WORD : rdata_a;
  assign tail_v      = empty ? EMPTY_WORD : rdata_b;
  assign done        = (state == S_RESP);
  assign front_value = rev ? tail_v : head_v;
  assign back_value  = rev ? head_v : tail_v;
  assign count       = COUNT_W'(occ);
  assign status      = stat_q;

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(DEPTH))
    else $error("occupancy above depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && !done)
    else $error("accepted command did not start");

  a_one_beat: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result beat longer than one cycle");

  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    done && (status == STAT_PUSH_FULL) |-> occ == OCC_W'(DEPTH))
    else $error("push dropped while not full");

  a_empty_words: assert property (@(posedge clk) disable iff (rst)
    done && empty |-> (front_value == EMPTY_WORD) && (back_value == EMPTY_WORD))
    else $error("empty queue shows data");

endmodule
`default_nettype wire

FILE: verif/rvdq_checker.sv
module rvdq_checker import rvdq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     busy,
  input  logic [CMD_W-1:0]         cmd,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     done,
  input  logic signed [DATA_W-1:0] front_value,
  input  logic signed [DATA_W-1:0] back_value,
  input  logic [COUNT_W-1:0]       count,
  input  logic [STAT_W-1:0]        status,
  output int                       fail_count,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    word_t               front;
    word_t               back;
    logic [COUNT_W-1:0]  count;
    logic [STAT_W-1:0]   status;
  } deque_view_t;

  // predicted deque contents
  word_t slot_word [DEPTH];
  int    head_slot;
  int    fill;
  logic  flipped;

  deque_view_t expected_views [$];

  task automatic apply_command(input logic [CMD_W-1:0] c, input word_t v,
                               output deque_view_t r);
    logic  at_tail;
    word_t head_w;
    word_t tail_w;
    r.status = STAT_OK;
    case (c)
      CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        // reversal swaps which physical end a logical end maps to
        at_tail = (c == CMD_PUSH_BACK) != flipped;
        if (fill >= DEPTH) begin
          r.status = STAT_PUSH_FULL;
        end else begin
          if (at_tail) begin
            slot_word[(head_slot + fill) % DEPTH] = v;
          end else begin
            head_slot = (head_slot == 0) ? DEPTH - 1 : head_slot - 1;
            slot_word[head_slot] = v;
          end
          fill++;
        end
      end
      CMD_POP_BACK, CMD_POP_FRONT: begin
        at_tail = (c == CMD_POP_BACK) != flipped;
        if (fill == 0) begin
          r.status = STAT_POP_EMPTY;
        end else begin
          if (!at_tail) head_slot = (head_slot + 1) % DEPTH;
          fill--;
          if (fill == 0) head_slot = 0;
        end
      end
      CMD_REVERSE: begin
        flipped = !flipped;
      end
      default: begin
      end
    endcase
    if (fill == 0) begin
      head_w = EMPTY_WORD;
      tail_w = EMPTY_WORD;
    end else begin
      head_w = slot_word[head_slot];
      tail_w = slot_word[(head_slot + fill - 1) % DEPTH];
    end
    r.front = flipped ? tail_w : head_w;
    r.back  = flipped ? head_w : tail_w;
    r.count = COUNT_W'(fill);
  endtask

  always @(posedge clk) begin
    deque_view_t want;
    deque_view_t made;
    if (rst) begin
      head_slot = 0;
      fill      = 0;
      flipped   = 1'b0;
      expected_views.delete();
    end else begin
      // check the result beat before taking the next command
      if (done) begin
        if (expected_views.size() == 0) begin
          $error("result beat with no command outstanding");
          fail_count++;
        end else begin
          want = expected_views.pop_front();
          if (front_value !== want.front) begin
            $error("front_value: expected %0d, got %0d", $signed(want.front), front_value);
            fail_count++;
          end
          if (back_value !== want.back) begin
            $error("back_value: expected %0d, got %0d", $signed(want.back), back_value);
            fail_count++;
          end
          if (count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, count);
            fail_count++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        apply_command(cmd, value, made);
        expected_views.insert(expected_views.size(), made);
      end
    end
    pending = expected_views.size();
  end

endmodule

FILE: verif/tb.sv
module tb import rvdq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = 16;
  localparam int RANDOM_BEATS = 700;
  localparam int IDLE_LIMIT   = 500;
  localparam int DRAIN_CYCLES = 12;

  // unused codes, the block treats them as a peek
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

  typedef enum logic [1:0] {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_mode_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic [CMD_W-1:0]         cmd = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     busy;
  logic                     done;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] back_value;
  logic [COUNT_W-1:0]       count;
  logic [STAT_W-1:0]        status;
  int                       fail_count;
  int                       pending;
  int                       idle_cycles = 0;

  word_t corner_words [6] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
                              32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa};

  initial begin
    forever #6 clk = ~clk;
  end

  reversible_deque_top #(.DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd), .value(value),
    .busy(busy), .done(done), .front_value(front_value), .back_value(back_value),
    .count(count), .status(status)
  );

  rvdq_checker #(.DEPTH(DEPTH)) checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .value(value),
    .done(done), .front_value(front_value), .back_value(back_value),
    .count(count), .status(status), .fail_count(fail_count), .pending(pending)
  );

  // hold the command until the block takes it
  task automatic issue(input logic [CMD_W-1:0] c, input word_t v);
    start <= 1'b1;
    cmd   <= c;
    value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic word_t pick_word();
    int r;
    r = $urandom_range(0, 11);
    if (r < 6) return corner_words[r];
    return $urandom;
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd(input traffic_mode_t mode);
    int r;
    int push_pct;
    int pop_pct;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_FILL:  begin push_pct = 70; pop_pct = 15; end
      MODE_DRAIN: begin push_pct = 15; pop_pct = 70; end
      default:    begin push_pct = 40; pop_pct = 40; end
    endcase
    if (r < push_pct) return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
    if (r < push_pct + pop_pct) return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
    case ($urandom_range(0, 3))
      0:       return CMD_REVERSE;
      1:       return CMD_PEEK;
      2:       return CMD_SPARE_A;
      default: return CMD_SPARE_B;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    traffic_mode_t mode;
    int            mode_left;
    int            burst_left;
    int            gap;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty queue: pops ignored, peeks and spare codes, reverse with nothing held
    issue(CMD_PEEK, 32'h0);
    issue(CMD_POP_BACK, 32'h7fff_ffff);
    issue(CMD_POP_FRONT, $urandom);
    issue(CMD_REVERSE, 32'h0);
    issue(CMD_SPARE_A, $urandom);
    issue(CMD_SPARE_B, $urandom);
    // fill while reversed, alternating ends so the first slot wraps below zero
    for (int i = 0; i < DEPTH; i++) begin
      issue((i % 2) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, (i < 6) ? corner_words[i] : $urandom);
    end
    issue(CMD_PUSH_BACK, 32'h1234_5678);
    issue(CMD_PUSH_FRONT, 32'h8765_4321);
    issue(CMD_REVERSE, 32'h0);
    issue(CMD_POP_FRONT, 32'h0);
    issue(CMD_POP_BACK, 32'h0);
    issue(CMD_PEEK, 32'h0);

    mode       = MODE_MIX;
    mode_left  = 0;
    burst_left = $urandom_range(1, 40);
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (mode_left == 0) begin
        mode      = traffic_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 60);
      end
      mode_left--;
      if (burst_left == 0) begin
        gap = $urandom_range(0, 7);
        if (gap != 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      issue(pick_cmd(mode), pick_word());
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if ((fail_count == 0) && (pending == 0)) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
